/* rtl/plsc_pkg.sv */
// ----------------------------------------------------------------------------
// plsc_pkg
// Shared types, codes and widths of the piecewise-linear sensor calibrator.
// ----------------------------------------------------------------------------
package plsc_pkg;

  localparam int unsigned TABLE_DEPTH = 64;   // default calibration table depth
  localparam int unsigned RAW_W       = 16;   // raw reading width
  localparam int unsigned VAL_W       = 15;   // table entry / grid step width
  localparam int unsigned RES_W       = 17;   // calibrated value width
  localparam int unsigned DIV_W       = 30;   // serial divider dividend width
  localparam int unsigned LEN_W       = $clog2(DIV_W + 1);
  localparam int unsigned ADDR_W      = 5;    // register file byte address width

  typedef enum logic {
    OP_CALIBRATE = 1'b0,
    OP_WRITE     = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STRAT_NONE    = 2'd0,
    STRAT_OFFSET  = 2'd1,
    STRAT_TABLE   = 2'd2,
    STRAT_UNKNOWN = 2'd3
  } strategy_e;

  typedef enum logic [2:0] {
    REG_STRATEGY     = 3'd0,
    REG_OFFSET       = 3'd1,
    REG_GRID_START   = 3'd2,
    REG_GRID_END     = 3'd3,
    REG_GRID_STEP    = 3'd4,
    REG_INVALID_CODE = 3'd5
  } reg_idx_e;

  typedef struct packed {
    op_e                       operation;
    logic signed [RAW_W-1:0]   raw_reading;
    logic        [5:0]         entry_index;
    logic        [VAL_W-1:0]   entry_value;
  } in_req_t;

  typedef struct packed {
    logic signed [RES_W-1:0]   calibrated_value;
    logic                      valid_res;
  } out_rsp_t;

  typedef struct packed {
    strategy_e                 strategy;
    logic signed [RAW_W-1:0]   offset;
    logic signed [RAW_W-1:0]   grid_start;
    logic signed [RAW_W-1:0]   grid_end;
    logic        [VAL_W-1:0]   grid_step;
    logic signed [RAW_W-1:0]   invalid_code;
  } cfg_t;

endpackage

/* rtl/plsc_regs.sv */
// ----------------------------------------------------------------------------
// plsc_regs
// APB-style configuration registers of the calibrator.
// ----------------------------------------------------------------------------
module plsc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output plsc_pkg::cfg_t                cfg_o
);

  plsc_pkg::cfg_t     cfg_q;
  plsc_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = plsc_pkg::reg_idx_e'(paddr[plsc_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strategy     <= plsc_pkg::STRAT_NONE;
      cfg_q.offset       <= 16'sd0;
      cfg_q.grid_start   <= 16'sd0;
      cfg_q.grid_end     <= 16'sd63;
      cfg_q.grid_step    <= 15'd1;
      cfg_q.invalid_code <= 16'sh8000;
    end else if (wr_en) begin
      case (idx)
        plsc_pkg::REG_STRATEGY:     cfg_q.strategy     <= plsc_pkg::strategy_e'(pwdata[1:0]);
        plsc_pkg::REG_OFFSET:       cfg_q.offset       <= pwdata[15:0];
        plsc_pkg::REG_GRID_START:   cfg_q.grid_start   <= pwdata[15:0];
        plsc_pkg::REG_GRID_END:     cfg_q.grid_end     <= pwdata[15:0];
        plsc_pkg::REG_GRID_STEP:    cfg_q.grid_step    <= pwdata[14:0];
        plsc_pkg::REG_INVALID_CODE: cfg_q.invalid_code <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Sign-extend the signed registers on readback.
  always_comb begin
    case (idx)
      plsc_pkg::REG_STRATEGY:     prdata = {30'd0, cfg_q.strategy};
      plsc_pkg::REG_OFFSET:       prdata = {{16{cfg_q.offset[15]}}, cfg_q.offset};
      plsc_pkg::REG_GRID_START:   prdata = {{16{cfg_q.grid_start[15]}}, cfg_q.grid_start};
      plsc_pkg::REG_GRID_END:     prdata = {{16{cfg_q.grid_end[15]}}, cfg_q.grid_end};
      plsc_pkg::REG_GRID_STEP:    prdata = {17'd0, cfg_q.grid_step};
      plsc_pkg::REG_INVALID_CODE: prdata = {{16{cfg_q.invalid_code[15]}}, cfg_q.invalid_code};
      default:                    prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/plsc_serdiv.sv */
// ----------------------------------------------------------------------------
// plsc_serdiv
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plsc_serdiv (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [plsc_pkg::DIV_W-1:0]    dividend_i,  // left-aligned
  input  logic [plsc_pkg::VAL_W-1:0]    divisor_i,
  input  logic [plsc_pkg::LEN_W-1:0]    len_i,       // quotient bits to produce
  output logic                          done_o,
  output logic [plsc_pkg::DIV_W-1:0]    quot_o,
  output logic [plsc_pkg::VAL_W-1:0]    rem_o
);

  localparam int unsigned DW = plsc_pkg::DIV_W;
  localparam int unsigned VW = plsc_pkg::VAL_W;

  logic                           busy_q, done_q;
  logic [plsc_pkg::LEN_W-1:0]     cnt_q;
  logic [DW-1:0]                  num_q, quot_q;
  logic [VW-1:0]                  rem_q, dsr_q;
  logic [VW:0]                    trial, diff;
  logic                           fits;

  // Bring down the next dividend bit and try the subtraction.
  assign trial = {rem_q, num_q[DW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= len_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == plsc_pkg::LEN_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= dividend_i;
      dsr_q  <= divisor_i;
      quot_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[DW-2:0], 1'b0};
      quot_q <= {quot_q[DW-2:0], fits};
      rem_q  <= fits ? diff[VW-1:0] : trial[VW-1:0];
    end
  end

endmodule

/* rtl/plsc_sermul.sv */
// ----------------------------------------------------------------------------
// plsc_sermul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module plsc_sermul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [plsc_pkg::VAL_W-1:0]    mcand_i,
  input  logic [plsc_pkg::VAL_W-1:0]    mplier_i,
  output logic                          done_o,
  output logic [plsc_pkg::DIV_W-1:0]    prod_o
);

  localparam int unsigned VW = plsc_pkg::VAL_W;
  localparam int unsigned PW = plsc_pkg::DIV_W;

  logic                           busy_q, done_q;
  logic [plsc_pkg::LEN_W-1:0]     cnt_q;
  logic [VW-1:0]                  mcand_q, mplier_q;
  logic [PW-1:0]                  acc_q;
  logic [PW-1:0]                  addend;

  assign addend = mplier_q[VW-1] ? PW'(mcand_q) : '0;
  assign done_o = done_q;
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= plsc_pkg::LEN_W'(VW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == plsc_pkg::LEN_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      acc_q    <= '0;
    end else if (busy_q) begin
      acc_q    <= {acc_q[PW-2:0], 1'b0} + addend;
      mplier_q <= {mplier_q[VW-2:0], 1'b0};
    end
  end

endmodule

/* rtl/piecewise_linear_sensor_calibrator.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_sensor_calibrator
// Calibrates raw readings by pass-through, offset or table interpolation.
// ----------------------------------------------------------------------------
// Sequence: pass-through and offset results go from the checks to the
//   output; table lookups run a serial 16-bit index divide, and when
//   interpolating also a 15-bit multiply and a 30-bit divide, 1 bit/cycle.
// Throughput: one request at a time; the next is taken once the result moves
//   to the output register. Table writes leave the sequencer idle.
// Reset: clear control state and restore register defaults; keep the table.
// ----------------------------------------------------------------------------
module piecewise_linear_sensor_calibrator #(
  parameter int unsigned TableDepth = plsc_pkg::TABLE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  plsc_pkg::in_req_t             in_req_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output plsc_pkg::out_rsp_t            out_rsp_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned IdxW  = $clog2(TableDepth);
  localparam int unsigned DepW  = $clog2(TableDepth + 1);
  localparam int unsigned ProdW = plsc_pkg::VAL_W + DepW;
  localparam int unsigned RawW  = plsc_pkg::RAW_W;
  localparam int unsigned ValW  = plsc_pkg::VAL_W;
  localparam int unsigned ResW  = plsc_pkg::RES_W;
  localparam int unsigned DivW  = plsc_pkg::DIV_W;

  // Sequencer states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CHECK  = 9'b000000010,  // range checks, simple strategies
    ST_DIV_K  = 9'b000000100,  // grid index and remainder
    ST_RD_LO  = 9'b000001000,  // read lower entry
    ST_RD_HI  = 9'b000010000,  // lower entry back, read upper entry
    ST_GET_HI = 9'b000100000,  // upper entry back, start multiply
    ST_MUL    = 9'b001000000,
    ST_DIV_F  = 9'b010000000,  // scale the slope term by the step
    ST_EMIT   = 9'b100000000
  } state_e;

  state_e                    state_q, state_d;
  plsc_pkg::cfg_t            cfg;

  // Request and working registers
  logic signed [RawW-1:0]    x_q;
  logic [RawW-1:0]           d_q;
  logic [IdxW-1:0]           k_q;
  logic [ValW-1:0]           rem_q;
  logic [ValW-1:0]           lo_q;
  logic                      neg_q;
  logic signed [ResW-1:0]    res_q;
  logic                      ok_q;

  // Output register
  logic                      out_valid_q;
  plsc_pkg::out_rsp_t        out_rsp_q;

  // Table memory, one write and one registered read port
  logic [ValW-1:0]           mem [TableDepth];
  logic [ValW-1:0]           rd_data_q;
  logic [IdxW-1:0]           rd_addr;
  logic                      mem_we;

  // Serial arithmetic
  logic                          div_start, div_done;
  logic [DivW-1:0]               div_dividend, div_quot;
  logic [plsc_pkg::LEN_W-1:0]    div_len;
  logic [ValW-1:0]               div_rem;
  logic                          mul_start, mul_done;
  logic [ValW-1:0]               mul_mcand;
  logic [DivW-1:0]               mul_prod;

  // Combinational helpers
  logic                      accept, out_free;
  logic signed [ResW-1:0]    x17, inv17, off17, start17, end17, span17;
  logic [ResW-1:0]           span_u;
  logic [ProdW-1:0]          depth_span;
  logic signed [ResW-1:0]    diff17;
  logic [RawW-1:0]           d_next;
  logic [ResW:0]             next_pt;
  logic [RawW-1:0]           hl_diff;
  logic [ValW-1:0]           hl_mag;
  logic                      in_grid;
  logic                      load_res, res_ok;
  logic signed [ResW-1:0]    res_val;

  plsc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  plsc_serdiv u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cfg.grid_step),
    .len_i      (div_len),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  plsc_sermul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (mul_mcand),
    .mplier_i (rem_q),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  // Take a request only while the sequencer is idle; a waiting result sits
  // in the output register and does not block the next request.
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_free   = ~out_valid_q | ~out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Table writes go straight to memory; indexes past the depth are dropped.
  assign mem_we = accept && (in_req_i.operation == plsc_pkg::OP_WRITE)
                  && (32'(in_req_i.entry_index) < TableDepth);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[IdxW'(in_req_i.entry_index)] <= in_req_i.entry_value;
    end
    rd_data_q <= mem[rd_addr];
  end

  // Grid geometry, widened to 17 bits so the span cannot overflow.
  assign x17     = {x_q[RawW-1], x_q};
  assign inv17   = {cfg.invalid_code[RawW-1], cfg.invalid_code};
  assign off17   = {cfg.offset[RawW-1], cfg.offset};
  assign start17 = {cfg.grid_start[RawW-1], cfg.grid_start};
  assign end17   = {cfg.grid_end[RawW-1], cfg.grid_end};
  assign span17  = end17 - start17;
  assign span_u  = span17;
  assign diff17  = x17 - start17;
  assign d_next  = diff17[RawW-1:0];

  // The grid holds more points than the table when span >= depth * step.
  assign depth_span = ProdW'(TableDepth) * ProdW'(cfg.grid_step);

  assign in_grid = (cfg.grid_step != '0)
                   && (x_q <= cfg.grid_end) && (x_q >= cfg.grid_start)
                   && (32'(span_u) < 32'(depth_span));

  // Offset from the grid start of the next grid point above the reading.
  assign next_pt = (ResW+1)'(d_q) - (ResW+1)'(div_rem) + (ResW+1)'(cfg.grid_step);

  // Slope numerator: |hi - lo| with its sign kept apart.
  assign hl_diff = {1'b0, rd_data_q} - {1'b0, lo_q};
  assign hl_mag  = hl_diff[RawW-1] ? ValW'(-hl_diff) : hl_diff[ValW-1:0];

  always_comb begin
    state_d      = state_q;
    load_res     = 1'b0;
    res_ok       = 1'b0;
    res_val      = '0;
    div_start    = 1'b0;
    div_dividend = {d_next, {(DivW-RawW){1'b0}}};
    div_len      = plsc_pkg::LEN_W'(RawW);
    mul_start    = 1'b0;
    mul_mcand    = hl_mag;
    rd_addr      = k_q;

    case (state_q)
      ST_IDLE: begin
        if (accept && (in_req_i.operation == plsc_pkg::OP_CALIBRATE)) begin
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (x_q == cfg.invalid_code) begin
          load_res = 1'b1;
          state_d  = ST_EMIT;
        end else begin
          case (cfg.strategy)
            plsc_pkg::STRAT_NONE: begin
              load_res = 1'b1;
              res_ok   = 1'b1;
              res_val  = x17;
              state_d  = ST_EMIT;
            end
            plsc_pkg::STRAT_OFFSET: begin
              load_res = 1'b1;
              res_ok   = 1'b1;
              res_val  = x17 + off17;
              state_d  = ST_EMIT;
            end
            plsc_pkg::STRAT_TABLE: begin
              if (in_grid) begin
                div_start = 1'b1;
                state_d   = ST_DIV_K;
              end else begin
                load_res = 1'b1;
                state_d  = ST_EMIT;
              end
            end
            default: begin
              load_res = 1'b1;
              state_d  = ST_EMIT;
            end
          endcase
        end
      end

      ST_DIV_K: begin
        if (div_done) begin
          // Between grid points with no point above inside the grid: invalid.
          if ((div_rem != '0) && (next_pt > (ResW+1)'(span_u))) begin
            load_res = 1'b1;
            state_d  = ST_EMIT;
          end else begin
            state_d = ST_RD_LO;
          end
        end
      end

      ST_RD_LO: begin
        state_d = ST_RD_HI;
      end

      ST_RD_HI: begin
        rd_addr = k_q + 1'b1;
        if (rem_q == '0) begin
          load_res = 1'b1;
          res_ok   = 1'b1;
          res_val  = ResW'(rd_data_q);
          state_d  = ST_EMIT;
        end else begin
          state_d = ST_GET_HI;
        end
      end

      ST_GET_HI: begin
        mul_start = 1'b1;
        state_d   = ST_MUL;
      end

      ST_MUL: begin
        div_dividend = mul_prod;
        div_len      = plsc_pkg::LEN_W'(DivW);
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV_F;
        end
      end

      ST_DIV_F: begin
        if (div_done) begin
          load_res = 1'b1;
          res_ok   = 1'b1;
          res_val  = neg_q ? (ResW'(lo_q) - ResW'(div_quot[ValW-1:0]))
                           : (ResW'(lo_q) + ResW'(div_quot[ValW-1:0]));
          state_d  = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == ST_EMIT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= in_req_i.raw_reading;
    end
    if (div_start && (state_q == ST_CHECK)) begin
      d_q <= d_next;
    end
    if ((state_q == ST_DIV_K) && div_done) begin
      k_q   <= div_quot[IdxW-1:0];
      rem_q <= div_rem;
    end
    if (state_q == ST_RD_HI) begin
      lo_q <= rd_data_q;
    end
    if (state_q == ST_GET_HI) begin
      neg_q <= hl_diff[RawW-1];
    end
    // A result equal to the sentinel is reported invalid.
    if (load_res) begin
      ok_q  <= res_ok && (res_val != inv17);
      res_q <= (res_ok && (res_val != inv17)) ? res_val : '0;
    end
    if ((state_q == ST_EMIT) && out_free) begin
      out_rsp_q.calibrated_value <= res_q;
      out_rsp_q.valid_res        <= ok_q;
    end
  end

endmodule

/* tb/piecewise_linear_sensor_calibrator_tb.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_sensor_calibrator_tb
// Self-checking bench: drives calibrate and table-write requests through the
// valid/stall channel, programs the registers over the APB port while the
// block is idle, and checks every result against a cycle-free predictor.
// ----------------------------------------------------------------------------
module piecewise_linear_sensor_calibrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  // Settling margin, above the longest request (interpolation).
  localparam int unsigned SETTLE_CYCLES = 100;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_stall_o;
  plsc_pkg::in_req_t             in_req_i    = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  plsc_pkg::out_rsp_t            out_rsp_o;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [plsc_pkg::ADDR_W-1:0]   paddr       = '0;
  logic [31:0]                   pwdata      = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // Predictor state: register shadow and calibration table shadow.
  plsc_pkg::cfg_t                shadow_cfg;
  logic [plsc_pkg::VAL_W-1:0]    shadow_table [plsc_pkg::TABLE_DEPTH];

  plsc_pkg::out_rsp_t            pending_results [$];
  int unsigned                   error_count = 0;
  int unsigned                   cycle_count = 0;
  int unsigned                   stall_left  = 0;
  bit                            quiet       = 1'b0;

  piecewise_linear_sensor_calibrator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side back-pressure: random bursts of stalled cycles,
  // none while the quiet flag is set.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 10);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk_i) begin : check_result
    plsc_pkg::out_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %0d valid %b",
                 $realtime, out_rsp_o.calibrated_value, out_rsp_o.valid_res);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_rsp_o.calibrated_value !== want.calibrated_value) begin
          $display("%0t: calibrated_value mismatch: expected %0d actual %0d",
                   $realtime, want.calibrated_value, out_rsp_o.calibrated_value);
          error_count++;
        end
        if (out_rsp_o.valid_res !== want.valid_res) begin
          $display("%0t: valid_res mismatch: expected %b actual %b",
                   $realtime, want.valid_res, out_rsp_o.valid_res);
          error_count++;
        end
      end
    end
  end

  // Work out the calibrated value of one reading under the shadow registers.
  function automatic plsc_pkg::out_rsp_t calibrate_reading(
      logic signed [plsc_pkg::RAW_W-1:0] raw);
    longint             x, v, gs, ge, step, cnt, k, rem, lo, hi;
    bit                 ok;
    plsc_pkg::out_rsp_t r;
    x    = raw;
    v    = 0;
    ok   = 1'b0;
    gs   = shadow_cfg.grid_start;
    ge   = shadow_cfg.grid_end;
    step = shadow_cfg.grid_step;
    if (raw != shadow_cfg.invalid_code) begin
      case (shadow_cfg.strategy)
        plsc_pkg::STRAT_NONE: begin
          v  = x;
          ok = 1'b1;
        end
        plsc_pkg::STRAT_OFFSET: begin
          v  = x + longint'(shadow_cfg.offset);
          ok = 1'b1;
        end
        plsc_pkg::STRAT_TABLE: begin
          if (step != 0 && x <= ge && x >= gs) begin
            cnt = (ge - gs) / step + 1;
            k   = (x - gs) / step;
            rem = (x - gs) % step;
            if (cnt <= longint'(plsc_pkg::TABLE_DEPTH) && k < cnt) begin
              lo = shadow_table[k];
              if (rem == 0) begin
                v  = lo;
                ok = 1'b1;
              end else if (k + 1 < cnt) begin
                // Interpolate; SV division truncates toward zero.
                hi = shadow_table[k + 1];
                v  = (rem * (hi - lo)) / step + lo;
                ok = 1'b1;
              end
            end
          end
        end
        default: ok = 1'b0;
      endcase
      // A computed value that equals the sentinel is reported invalid.
      if (ok && v == longint'(shadow_cfg.invalid_code)) ok = 1'b0;
    end
    if (!ok) v = 0;
    r.calibrated_value = v[plsc_pkg::RES_W-1:0];
    r.valid_res        = ok;
    return r;
  endfunction

  function automatic plsc_pkg::in_req_t sample_req(logic signed [plsc_pkg::RAW_W-1:0] raw);
    plsc_pkg::in_req_t r;
    r.operation   = plsc_pkg::OP_CALIBRATE;
    r.raw_reading = raw;
    r.entry_index = 6'($urandom());
    r.entry_value = plsc_pkg::VAL_W'($urandom());
    return r;
  endfunction

  function automatic plsc_pkg::in_req_t write_req(logic [5:0] idx,
                                                  logic [plsc_pkg::VAL_W-1:0] val);
    plsc_pkg::in_req_t r;
    r.operation   = plsc_pkg::OP_WRITE;
    r.raw_reading = plsc_pkg::RAW_W'($urandom());
    r.entry_index = idx;
    r.entry_value = val;
    return r;
  endfunction

  // Pick a reading that mostly lands on or near the current grid.
  function automatic logic signed [plsc_pkg::RAW_W-1:0] grid_reading();
    longint gs, ge, step, r, cnt;
    int     sel;
    gs   = shadow_cfg.grid_start;
    ge   = shadow_cfg.grid_end;
    step = shadow_cfg.grid_step;
    sel  = $urandom_range(0, 99);
    r    = 40000;
    if (sel < 45 && step != 0 && ge >= gs) begin
      cnt = (ge - gs) / step + 1;
      if (cnt > 90) cnt = 90;
      r = gs + longint'($urandom_range(0, int'(cnt))) * step;
    end else if (sel < 85 && ge >= gs) begin
      r = gs - 2 + longint'($urandom_range(0, int'(ge - gs + 4)));
    end else if (sel < 92) begin
      r = shadow_cfg.invalid_code;
    end
    if (r > 32767 || r < -32768) r = longint'($signed(16'($urandom())));
    return r[plsc_pkg::RAW_W-1:0];
  endfunction

  // Send one request, with an optional random gap first; predict on accept.
  task automatic send_req(plsc_pkg::in_req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (r.operation == plsc_pkg::OP_WRITE) begin
      shadow_table[r.entry_index] = r.entry_value;
    end else begin
      pending_results.push_back(calibrate_reading(r.raw_reading));
    end
  endtask

  // Drop valid and hold until every predicted result has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then let a trailing table write or late request finish.
  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle until pready, then an idle cycle.
  task automatic set_reg(plsc_pkg::reg_idx_e idx, int val);
    logic [31:0] d;
    d = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      plsc_pkg::REG_STRATEGY:     shadow_cfg.strategy     = plsc_pkg::strategy_e'(d[1:0]);
      plsc_pkg::REG_OFFSET:       shadow_cfg.offset       = d[15:0];
      plsc_pkg::REG_GRID_START:   shadow_cfg.grid_start   = d[15:0];
      plsc_pkg::REG_GRID_END:     shadow_cfg.grid_end     = d[15:0];
      plsc_pkg::REG_GRID_STEP:    shadow_cfg.grid_step    = d[14:0];
      plsc_pkg::REG_INVALID_CODE: shadow_cfg.invalid_code = d[15:0];
      default: ;
    endcase
  endtask

  // Program a table grid. Shape 1: widest step over the full range;
  // shape 2: unit step filling the table at the top of the range; shape 3:
  // more grid points than the table holds; otherwise random (sometimes end below start).
  task automatic set_grid(int shape);
    int step, n, span, start;
    case (shape)
      1: begin
        step  = 32767;
        start = -32768;
        span  = 65535;
      end
      2: begin
        step  = 1;
        start = 32767 - 63;
        span  = 63;
      end
      3: begin
        step  = $urandom_range(1, 500);
        n     = $urandom_range(plsc_pkg::TABLE_DEPTH + 1, plsc_pkg::TABLE_DEPTH + 16);
        span  = (n - 1) * step + $urandom_range(0, step - 1);
        start = -32768 + $urandom_range(0, 65535 - span);
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       step = 1;
          1:       step = $urandom_range(2, 40);
          2:       step = $urandom_range(41, 2000);
          default: step = $urandom_range(2001, 32767);
        endcase
        n     = $urandom_range(1, (65536 / step < plsc_pkg::TABLE_DEPTH) ?
                                  65536 / step : plsc_pkg::TABLE_DEPTH);
        span  = (n - 1) * step + $urandom_range(0, step - 1);
        start = -32768 + $urandom_range(0, 65535 - span);
        if ($urandom_range(0, 9) == 0) begin
          // End below start: every lookup out of grid.
          span  = -int'($urandom_range(1, 100));
          start = $urandom_range(0, 32767);
        end
      end
    endcase
    set_reg(plsc_pkg::REG_STRATEGY, plsc_pkg::STRAT_TABLE);
    set_reg(plsc_pkg::REG_GRID_START, start);
    set_reg(plsc_pkg::REG_GRID_END, start + span);
    set_reg(plsc_pkg::REG_GRID_STEP, step);
  endtask

  // Pass-through, offset and unknown strategy, with the sentinel cases.
  task automatic test_direct_modes();
    send_req(sample_req(16'sh7FFF));
    send_req(sample_req(-16'sd32767));
    send_req(sample_req(16'sd0));
    send_req(sample_req(-16'sd32768));       // sentinel at reset
    wait_idle();
    set_reg(plsc_pkg::REG_STRATEGY, plsc_pkg::STRAT_OFFSET);
    set_reg(plsc_pkg::REG_OFFSET, 32767);
    send_req(sample_req(16'sh7FFF));
    send_req(sample_req(-16'sd32767));
    wait_idle();
    set_reg(plsc_pkg::REG_OFFSET, -32768);
    send_req(sample_req(-16'sd32767));
    wait_idle();
    // Result lands on the sentinel: reported invalid.
    set_reg(plsc_pkg::REG_OFFSET, 32767);
    set_reg(plsc_pkg::REG_INVALID_CODE, 100);
    send_req(sample_req(-16'sd32667));
    send_req(sample_req(-16'sd32768));
    wait_idle();
    set_reg(plsc_pkg::REG_STRATEGY, plsc_pkg::STRAT_UNKNOWN);
    send_req(sample_req(16'sd5));
    wait_idle();
  endtask

  // Table lookups: grid points, interpolation both ways, sentinel hit,
  // past last grid point, out of grid, grid too wide, zero step.
  task automatic test_direct_table();
    send_req(write_req(6'd0, 15'd0));
    send_req(write_req(6'd1, 15'd32767));
    send_req(write_req(6'd2, 15'd100));
    wait_idle();
    set_reg(plsc_pkg::REG_STRATEGY, plsc_pkg::STRAT_TABLE);
    set_reg(plsc_pkg::REG_GRID_START, -32768);
    set_reg(plsc_pkg::REG_GRID_END, 32767);
    set_reg(plsc_pkg::REG_GRID_STEP, 32767);
    send_req(sample_req(-16'sd32768));
    send_req(sample_req(-16'sd2));
    send_req(sample_req(16'sd0));
    send_req(sample_req(16'sd32766));        // entry equals sentinel
    send_req(sample_req(16'sh7FFF));
    wait_idle();
    set_reg(plsc_pkg::REG_GRID_START, 0);
    set_reg(plsc_pkg::REG_GRID_END, 63);
    set_reg(plsc_pkg::REG_GRID_STEP, 1);
    send_req(sample_req(-16'sd1));
    send_req(sample_req(16'sd64));
    wait_idle();
    set_reg(plsc_pkg::REG_GRID_END, 64);
    send_req(sample_req(16'sd0));
    wait_idle();
    set_reg(plsc_pkg::REG_GRID_END, 63);
    set_reg(plsc_pkg::REG_GRID_STEP, 0);
    send_req(sample_req(16'sd0));
    wait_idle();
  endtask

  // Fill the whole table, then run grid settings with mixed reads and
  // rewrites. Pause once mid-phase until every result is back.
  task automatic test_table_random();
    for (int i = 0; i < plsc_pkg::TABLE_DEPTH; i++) begin
      send_req(write_req(6'(i), 15'($urandom())));
    end
    for (int ph = 0; ph < 9; ph++) begin
      wait_idle();
      set_grid(ph < 4 ? ph : 0);
      if ($urandom_range(0, 1) == 0) begin
        set_reg(plsc_pkg::REG_INVALID_CODE, $urandom_range(0, 32767));
      end
      for (int i = 0; i < 110; i++) begin
        if (ph == 0 && i == 55) wait_drained();
        if ($urandom_range(0, 99) < 15) begin
          send_req(write_req(6'($urandom()), 15'($urandom())));
        end else begin
          send_req(sample_req(grid_reading()));
        end
      end
    end
    wait_idle();
  endtask

  // All strategies with random offsets and sentinels; one phase quiet.
  task automatic test_mixed_random();
    int sel;
    logic signed [plsc_pkg::RAW_W-1:0] raw;
    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      quiet = (ph == 3);
      sel   = $urandom_range(0, 2);
      set_reg(plsc_pkg::REG_OFFSET,
              sel == 0 ? 32767 : sel == 1 ? -32768 : int'($signed(16'($urandom()))));
      set_reg(plsc_pkg::REG_INVALID_CODE, $signed(16'($urandom())));
      if (ph == 4) begin
        set_grid(0);
      end else begin
        set_reg(plsc_pkg::REG_STRATEGY, ph % 4 == 2 ? plsc_pkg::STRAT_UNKNOWN :
                (ph % 2 ? plsc_pkg::STRAT_OFFSET : plsc_pkg::STRAT_NONE));
      end
      for (int i = 0; i < 70; i++) begin
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
          send_req(write_req(6'($urandom()), 15'($urandom())));
        end else begin
          if (sel < 18) raw = shadow_cfg.invalid_code;
          else if (sel < 26) raw = shadow_cfg.invalid_code - shadow_cfg.offset;
          else if (shadow_cfg.strategy == plsc_pkg::STRAT_TABLE) raw = grid_reading();
          else raw = 16'($urandom());
          send_req(sample_req(raw));
        end
      end
    end
    quiet = 1'b0;
    wait_idle();
  endtask

  // Back-to-back requests with no idling on either side.
  task automatic test_full_rate();
    quiet = 1'b1;
    set_reg(plsc_pkg::REG_OFFSET, $signed(16'($urandom())));
    set_reg(plsc_pkg::REG_INVALID_CODE, -32768);
    set_grid(0);
    for (int i = 0; i < 250; i++) begin
      if (i == 125) begin
        wait_idle();
        set_reg(plsc_pkg::REG_STRATEGY, plsc_pkg::STRAT_OFFSET);
      end
      if ($urandom_range(0, 99) < 10) begin
        send_req(write_req(6'($urandom()), 15'($urandom())));
      end else if (shadow_cfg.strategy == plsc_pkg::STRAT_TABLE) begin
        send_req(sample_req(grid_reading()));
      end else begin
        send_req(sample_req(16'($urandom())));
      end
    end
  endtask

  initial begin
    shadow_cfg.strategy     = plsc_pkg::STRAT_NONE;
    shadow_cfg.offset       = '0;
    shadow_cfg.grid_start   = '0;
    shadow_cfg.grid_end     = 16'sd63;
    shadow_cfg.grid_step    = 15'd1;
    shadow_cfg.invalid_code = -16'sd32768;
    for (int i = 0; i < plsc_pkg::TABLE_DEPTH; i++) shadow_table[i] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_direct_modes();
    test_direct_table();
    test_table_random();
    test_mixed_random();
    test_full_rate();

    wait_idle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
